[src/lpcp_pkg.sv]
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared codes and helpers for the length-prefixed container parser.
// ----------------------------------------------------------------------------
package lpcp_pkg;

	localparam int unsigned SecW = 4;
	localparam int unsigned StW  = 3;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 32;

	localparam logic [SecW-1:0] SEC_HEADER  = 4'd0;
	localparam logic [SecW-1:0] SEC_FIRST   = 4'd1;
	localparam logic [SecW-1:0] SEC_NONCE   = 4'd3;
	localparam logic [SecW-1:0] SEC_TAG     = 4'd4;
	localparam logic [SecW-1:0] SEC_IGNORED = 4'd8;

	localparam logic [31:0] HDR_LAST_POS    = 32'd6;
	localparam logic [31:0] VERSION_POS     = 32'd4;
	localparam logic [31:0] PREFIX_LAST_POS = 32'd3;

	typedef enum logic [StW-1:0] {
		ST_BUSY        = 3'd0,
		ST_COMPLETE    = 3'd1,
		ST_BAD_HEADER  = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_SHORT_LEN   = 3'd4,
		ST_SHORT_VAR   = 3'd5,
		ST_SHORT_FIXED = 3'd6
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAGIC   = 2'd0,
		REG_VERSION = 2'd1,
		REG_NONCE   = 2'd2,
		REG_TAG     = 2'd3
	} reg_idx_t;

	localparam logic [31:0] MAGIC_RST   = 32'h5051_4300;
	localparam logic [7:0]  VERSION_RST = 8'd1;
	localparam logic [7:0]  NONCE_RST   = 8'd12;
	localparam logic [7:0]  TAG_RST     = 8'd16;

	typedef struct packed {
		logic [SecW-1:0] sec;
		logic [31:0]     len;
		logic            pfx;
		logic            done;
	} entry_t;

	// Enter a section, skipping empty fixed fields; past the last means done.
	function automatic entry_t enter_sec(logic [SecW-1:0] sec, logic [7:0] nonce_len,
			logic [7:0] tag_len);
		entry_t e;
		logic [SecW-1:0] s;
		s = sec;
		if (s == SEC_NONCE && nonce_len == 8'd0) begin
			s = SEC_TAG;
		end
		if (s == SEC_TAG && tag_len == 8'd0) begin
			s = s + 4'd1;
		end
		e.done = 1'b0;
		e.sec  = s;
		e.len  = 32'd0;
		e.pfx  = 1'b1;
		if (s >= SEC_IGNORED) begin
			e.sec  = SEC_IGNORED;
			e.done = 1'b1;
		end else if (s == SEC_NONCE) begin
			e.len = {24'd0, nonce_len};
			e.pfx = 1'b0;
		end else if (s == SEC_TAG) begin
			e.len = {24'd0, tag_len};
			e.pfx = 1'b0;
		end
		return e;
	endfunction

endpackage

[src/length_prefixed_container_parser.sv]
// ----------------------------------------------------------------------------
// length_prefixed_container_parser
// Labels each byte of a container stream with its section and verdict.
// ----------------------------------------------------------------------------
// A result is valid in the cycle after its item is accepted (one result register).
// Throughput: 1 item per cycle while results are taken; the result register
// frees as it is taken, so input ready follows output ready combinationally.
// Reset: clears parse state and result valid, loads configuration defaults.
// Parse state also returns to its reset values after each end-of-data item.
module length_prefixed_container_parser
	import lpcp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                end_of_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic [SecW-1:0]     section,
	output logic                is_contents,
	output logic                field_end,
	output logic [StW-1:0]      status
);

	logic [31:0]     magic_q;
	logic [7:0]      version_q;
	logic [7:0]      nonce_q;
	logic [7:0]      tag_q;

	logic [SecW-1:0] sec_q;
	logic [31:0]     pos_q;
	logic [31:0]     len_q;
	logic            pfx_q;
	logic            mm_q;
	logic            vm_q;
	status_t         fs_q;

	logic [SecW-1:0] sec_n;
	logic [31:0]     pos_n;
	logic [31:0]     len_n;
	logic            pfx_n;
	logic            mm_n;
	logic            vm_n;
	status_t         fs_n;
	logic            cont_n;
	logic            fend_n;
	logic [7:0]      want;
	logic [32:0]     pos_inc;
	entry_t          ent;

	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic [SecW-1:0] section_q;
	logic            contents_q;
	logic            fend_q;
	status_t         status_q;

	logic            accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MAGIC_RST;
			version_q <= VERSION_RST;
			nonce_q   <= NONCE_RST;
			tag_q     <= TAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAGIC:   magic_q   <= cfg_wdata;
				REG_VERSION: version_q <= cfg_wdata[7:0];
				REG_NONCE:   nonce_q   <= cfg_wdata[7:0];
				REG_TAG:     tag_q     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sec_n   = sec_q;
		pos_n   = pos_q;
		len_n   = len_q;
		pfx_n   = pfx_q;
		mm_n    = mm_q;
		vm_n    = vm_q;
		fs_n    = fs_q;
		cont_n  = 1'b0;
		fend_n  = 1'b0;
		ent     = enter_sec(sec_q + 4'd1, nonce_q, tag_q);
		pos_inc = {1'b0, pos_q} + 33'd1;
		case (pos_q[1:0])
			2'd0:    want = magic_q[31:24];
			2'd1:    want = magic_q[23:16];
			2'd2:    want = magic_q[15:8];
			default: want = magic_q[7:0];
		endcase

		if (sec_q == SEC_HEADER) begin
			if (pos_q < VERSION_POS) begin
				if (in_byte != want) begin
					mm_n = 1'b1;
				end
			end else if (pos_q == VERSION_POS) begin
				if (in_byte != version_q) begin
					vm_n = 1'b1;
				end
			end
			pos_n = pos_inc[31:0];
			if (pos_q == HDR_LAST_POS) begin
				pos_n = 32'd0;
				if (mm_n) begin
					fs_n  = ST_BAD_HEADER;
					sec_n = SEC_IGNORED;
				end else if (vm_n) begin
					fs_n  = ST_BAD_VERSION;
					sec_n = SEC_IGNORED;
				end else begin
					sec_n = SEC_FIRST;
					len_n = 32'd0;
					pfx_n = 1'b1;
				end
			end
		end else if (sec_q >= SEC_IGNORED) begin
			sec_n = sec_q;
		end else if (pfx_q) begin
			len_n = {len_q[23:0], in_byte};
			pos_n = pos_inc[31:0];
			if (pos_q == PREFIX_LAST_POS) begin
				pos_n = 32'd0;
				if (len_n == 32'd0) begin
					sec_n = ent.sec;
					len_n = ent.len;
					pfx_n = ent.pfx;
					if (ent.done) begin
						fs_n = ST_COMPLETE;
					end
				end else begin
					pfx_n = 1'b0;
				end
			end
		end else begin
			cont_n = 1'b1;
			if (pos_inc >= {1'b0, len_q}) begin
				fend_n = 1'b1;
				pos_n  = 32'd0;
				sec_n  = ent.sec;
				len_n  = ent.len;
				pfx_n  = ent.pfx;
				if (ent.done) begin
					fs_n = ST_COMPLETE;
				end
			end else begin
				pos_n = pos_inc[31:0];
			end
		end

		if (end_of_data && fs_n == ST_BUSY) begin
			if (sec_n == SEC_HEADER) begin
				fs_n = ST_BAD_HEADER;
			end else if (sec_n == SEC_NONCE || sec_n == SEC_TAG) begin
				fs_n = ST_SHORT_FIXED;
			end else if (pfx_n) begin
				fs_n = ST_SHORT_LEN;
			end else begin
				fs_n = ST_SHORT_VAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= SEC_HEADER;
			pos_q <= 32'd0;
			len_q <= 32'd0;
			pfx_q <= 1'b1;
			mm_q  <= 1'b0;
			vm_q  <= 1'b0;
			fs_q  <= ST_BUSY;
		end else if (accept) begin
			if (end_of_data) begin
				sec_q <= SEC_HEADER;
				pos_q <= 32'd0;
				len_q <= 32'd0;
				pfx_q <= 1'b1;
				mm_q  <= 1'b0;
				vm_q  <= 1'b0;
				fs_q  <= ST_BUSY;
			end else begin
				sec_q <= sec_n;
				pos_q <= pos_n;
				len_q <= len_n;
				pfx_q <= pfx_n;
				mm_q  <= mm_n;
				vm_q  <= vm_n;
				fs_q  <= fs_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= in_byte;
			section_q  <= sec_q;
			contents_q <= cont_n;
			fend_q     <= fend_n;
			status_q   <= fs_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign section     = section_q;
	assign is_contents = contents_q;
	assign field_end   = fend_q;
	assign status      = status_q;

`ifndef SYNTH
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

	a_fend_contents: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_end |-> is_contents)
		else $error("field end outside field contents");

	a_ignored_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && section == SEC_IGNORED |-> status != ST_BUSY && !is_contents)
		else $error("ignored item without a verdict");

	a_prefix_pos: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q != SEC_HEADER && sec_q != SEC_IGNORED && pfx_q |-> pos_q <= PREFIX_LAST_POS)
		else $error("length prefix position out of range");
`endif

endmodule

[dv/tb_length_prefixed_container_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_container_parser
// Streams whole and cut-short containers through the parser under several
// register settings and random valid/ready gaps. Every byte label the block
// returns is checked, field by field, against a local byte-by-byte predictor.
// ----------------------------------------------------------------------------
module tb_length_prefixed_container_parser;
	import lpcp_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct {
		logic [7:0]      data;
		logic [SecW-1:0] sec;
		logic            contents;
		logic            fend;
		status_t         verdict;
	} label_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          in_byte = 8'd0;
	logic                end_of_data = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          out_byte;
	logic [SecW-1:0]     section;
	logic                is_contents;
	logic                field_end;
	logic [StW-1:0]      status;

	length_prefixed_container_parser uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_data (end_of_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.section     (section),
		.is_contents (is_contents),
		.field_end   (field_end),
		.status      (status)
	);

	always #4 clk = ~clk;

	item_t  pending_bytes[$];
	label_t expected_labels[$];
	int     send_idle = 32;
	int     recv_idle = 48;
	int     errors = 0;

	logic [31:0] cfg_magic = MAGIC_RST;
	logic [7:0]  cfg_version = VERSION_RST;
	logic [7:0]  cfg_nonce = NONCE_RST;
	logic [7:0]  cfg_tag = TAG_RST;

	logic [SecW-1:0] sec_now = SEC_HEADER;
	logic [31:0]     pos = 32'd0;
	logic [31:0]     flen = 32'd0;
	logic            in_pfx = 1'b1;
	logic            magic_bad = 1'b0;
	logic            ver_bad = 1'b0;
	status_t         verdict = ST_BUSY;

	function automatic logic [7:0] magic_at(input logic [31:0] i);
		logic [7:0] b;
		b = 8'(cfg_magic >> (8 * (3 - i)));
		return b;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void clear_parse();
		sec_now = SEC_HEADER;
		pos = 32'd0;
		flen = 32'd0;
		in_pfx = 1'b1;
		magic_bad = 1'b0;
		ver_bad = 1'b0;
		verdict = ST_BUSY;
	endfunction

	// skip empty fixed fields; running past the last field completes
	function automatic void open_field(input logic [SecW-1:0] s);
		logic [SecW-1:0] n;
		n = s;
		if (n == SEC_NONCE && cfg_nonce == 8'd0) n = SEC_TAG;
		if (n == SEC_TAG && cfg_tag == 8'd0) n = n + 4'd1;
		if (n >= SEC_IGNORED) begin
			sec_now = SEC_IGNORED;
			verdict = ST_COMPLETE;
		end else if (n == SEC_NONCE || n == SEC_TAG) begin
			sec_now = n;
			flen = (n == SEC_NONCE) ? {24'd0, cfg_nonce} : {24'd0, cfg_tag};
			in_pfx = 1'b0;
			pos = 32'd0;
		end else begin
			sec_now = n;
			flen = 32'd0;
			in_pfx = 1'b1;
			pos = 32'd0;
		end
	endfunction

	function automatic label_t label_byte(input logic [7:0] b, input logic last);
		label_t r;
		r.data = b;
		r.sec = sec_now;
		r.contents = 1'b0;
		r.fend = 1'b0;
		if (sec_now == SEC_HEADER) begin
			if (pos < VERSION_POS) begin
				if (b != magic_at(pos)) magic_bad = 1'b1;
			end else if (pos == VERSION_POS) begin
				if (b != cfg_version) ver_bad = 1'b1;
			end
			pos = pos + 32'd1;
			if (pos > HDR_LAST_POS) begin
				if (magic_bad) begin
					verdict = ST_BAD_HEADER;
					sec_now = SEC_IGNORED;
				end else if (ver_bad) begin
					verdict = ST_BAD_VERSION;
					sec_now = SEC_IGNORED;
				end else begin
					open_field(SEC_FIRST);
				end
			end
		end else if (sec_now >= SEC_IGNORED) begin
		end else if (in_pfx) begin
			flen = {flen[23:0], b};
			pos = pos + 32'd1;
			if (pos > PREFIX_LAST_POS) begin
				if (flen == 32'd0) begin
					open_field(sec_now + 4'd1);
				end else begin
					in_pfx = 1'b0;
					pos = 32'd0;
				end
			end
		end else begin
			r.contents = 1'b1;
			if ({1'b0, pos} + 33'd1 >= {1'b0, flen}) begin
				r.fend = 1'b1;
				open_field(sec_now + 4'd1);
			end else begin
				pos = pos + 32'd1;
			end
		end
		if (last && verdict == ST_BUSY) begin
			if (sec_now == SEC_HEADER) verdict = ST_BAD_HEADER;
			else if (sec_now == SEC_NONCE || sec_now == SEC_TAG) verdict = ST_SHORT_FIXED;
			else if (in_pfx) verdict = ST_SHORT_LEN;
			else verdict = ST_SHORT_VAR;
		end
		r.verdict = verdict;
		if (last) clear_parse();
		return r;
	endfunction

	function automatic void push_item(input logic [7:0] b, input logic last);
		item_t it;
		it.data = b;
		it.last = last;
		pending_bytes = {pending_bytes, it};
	endfunction

	// mostly well-formed containers; some with a bad header, a huge length or a cut
	function automatic int add_container();
		logic [7:0]  img[$];
		logic [31:0] len;
		int          pick;
		int          cut;
		int          n;
		bit          huge;
		huge = 1'b0;
		for (int i = 0; i < 4; i++) img = {img, magic_at(i)};
		img = {img, cfg_version};
		img = {img, rand_byte()};
		img = {img, rand_byte()};
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			n = $urandom_range(0, 3);
			img[n] = img[n] ^ 8'($urandom_range(1, 255));
		end else if (pick < 16) begin
			img[VERSION_POS] = img[VERSION_POS] ^ 8'($urandom_range(1, 255));
		end
		for (int s = 1; s <= 7 && !huge; s++) begin
			if (s == SEC_NONCE) begin
				len = {24'd0, cfg_nonce};
			end else if (s == SEC_TAG) begin
				len = {24'd0, cfg_tag};
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 30) len = 32'd0;
				else if (pick < 84) len = $urandom_range(1, 6);
				else if (pick < 96) len = $urandom_range(7, 20);
				else if (pick < 98) len = 32'hFFFF_FFFF;
				else len = $urandom | 32'h100;
				img = {img, len[31:24]};
				img = {img, len[23:16]};
				img = {img, len[15:8]};
				img = {img, len[7:0]};
				if (len > 32'd255) begin
					huge = 1'b1;
					len = $urandom_range(0, 5);
				end
			end
			repeat (len) img = {img, rand_byte()};
		end
		if (!huge && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) img = {img, rand_byte()};
		end
		cut = img.size();
		if (!huge && $urandom_range(0, 99) < 25) cut = $urandom_range(1, img.size());
		for (int i = 0; i < cut; i++) push_item(img[i], i == cut - 1);
		return cut;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_bytes
		item_t  nxt;
		label_t got;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				got = label_byte(in_byte, end_of_data);
				expected_labels = {expected_labels, got};
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					nxt = pending_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.data;
					end_of_data <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_labels
		label_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_labels.size() == 0) begin
					$error("unexpected label for byte %0h", out_byte);
					errors++;
				end else begin
					want = expected_labels.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte expected %0h got %0h", want.data, out_byte);
						errors++;
					end
					if (section !== want.sec) begin
						$error("section expected %0d got %0d", want.sec, section);
						errors++;
					end
					if (is_contents !== want.contents) begin
						$error("is_contents expected %0d got %0d", want.contents, is_contents);
						errors++;
					end
					if (field_end !== want.fend) begin
						$error("field_end expected %0d got %0d", want.fend, field_end);
						errors++;
					end
					if (status !== want.verdict) begin
						$error("status expected %0d got %0d", want.verdict, status);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || in_valid || expected_labels.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_MAGIC: cfg_magic = val;
			REG_VERSION: cfg_version = val[7:0];
			REG_NONCE: cfg_nonce = val[7:0];
			REG_TAG: cfg_tag = val[7:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input logic [31:0] magic, input logic [7:0] ver,
			input logic [7:0] nonce, input logic [7:0] tag, input int budget);
		int count;
		wait_idle();
		write_reg(REG_MAGIC, magic);
		write_reg(REG_VERSION, {24'd0, ver});
		write_reg(REG_NONCE, {24'd0, nonce});
		write_reg(REG_TAG, {24'd0, tag});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		count = 0;
		while (count < budget) count += add_container();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(8'hFF, 1'b1);
		for (int i = 0; i < 4; i++) push_item(magic_at(i), 1'b0);
		push_item(cfg_version, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(~magic_at(0), 1'b0);
		for (int i = 1; i < 4; i++) push_item(magic_at(i), 1'b0);
		push_item(~cfg_version, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b1);
		for (int i = 0; i < 4; i++) push_item(magic_at(i), 1'b0);
		push_item(cfg_version ^ 8'h80, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h5A, 1'b1);

		run_phase(MAGIC_RST, VERSION_RST, NONCE_RST, TAG_RST, 150);
		run_phase(32'd0, 8'd0, 8'd0, 8'd0, 150);
		wait_idle();
		send_idle = 48;
		recv_idle = 32;
		run_phase(32'hFFFF_FFFF, 8'hFF, 8'd255, 8'd1, 200);
		run_phase($urandom, rand_byte(), 8'd1, 8'd255, 200);
		wait_idle();
		send_idle = 0;
		recv_idle = 0;
		run_phase($urandom, rand_byte(), 8'd0, 8'($urandom_range(1, 20)), 150);
		run_phase($urandom, rand_byte(), 8'($urandom_range(1, 20)), 8'd0, 150);
		run_phase($urandom, rand_byte(), 8'($urandom_range(0, 20)),
			8'($urandom_range(0, 20)), 150);

		wait_idle();
		repeat (5) @(posedge clk);
		if (errors == 0) begin
			$display("PASS length_prefixed_container_parser");
		end else begin
			$display("FAIL length_prefixed_container_parser");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL length_prefixed_container_parser");
		$finish;
	end

endmodule

[filelist.f]
src/lpcp_pkg.sv
src/length_prefixed_container_parser.sv
dv/tb_length_prefixed_container_parser.sv
